// ===== src/wad_pkg.sv =====
// Package for the word archive deframer: codes, constants and the queue entry type.
// No dependencies; every other file of the block refers to it by scoped names.
package wad_pkg;

	localparam int WORD_W = 36;
	localparam int LOOK_DEPTH = 6;
	localparam int QDEPTH = 4;
	localparam int REM_W = 19;
	localparam int MCNT_W = 16;

	localparam logic [WORD_W-1:0] MAGIC_WORD = 36'o014777252031;
	localparam logic [WORD_W-1:0] USER_MASK  = 36'o0633126423275;
	localparam logic [REM_W-1:0]  REMAIN_MAX = 19'h7FFFF;

	typedef enum logic [2:0] {
		KIND_PREAMBLE  = 3'd0,
		KIND_USER      = 3'd1,
		KIND_MAGIC     = 3'd2,
		KIND_NAME1     = 3'd3,
		KIND_NAME2     = 3'd4,
		KIND_TIMESTAMP = 3'd5,
		KIND_LENGTH    = 3'd6,
		KIND_DATA      = 3'd7
	} wad_kind_t;

	typedef enum logic [2:0] {
		FMT_OFF0    = 3'd0,
		FMT_OFF1    = 3'd1,
		FMT_OFF4    = 3'd2,
		FMT_OFF5    = 3'd3,
		FMT_UNKNOWN = 3'd4
	} wad_fmt_t;

	// Classification made by the front part
	typedef enum logic [1:0] {
		SK_PREAMBLE,
		SK_USER,
		SK_MEMBER
	} wad_src_kind_t;

	typedef enum logic [1:0] {
		FS_COLLECT,
		FS_DETECT,
		FS_REPLAY,
		FS_PASS
	} wad_front_state_t;

	typedef enum logic [2:0] {
		HP_MAGIC,
		HP_NAME1,
		HP_NAME2,
		HP_STAMP,
		HP_LENGTH,
		HP_DATA
	} wad_hdr_pos_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		wad_src_kind_t     skind;
		wad_fmt_t          fmt;
		logic              last;
		logic              eos;
	} wad_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wad_q_stat_t;

	typedef struct packed {
		wad_kind_t         word_kind;
		logic [WORD_W-1:0] word_value;
		logic [MCNT_W-1:0] member_number;
		wad_fmt_t          format_code;
		logic              magic_error;
		logic              member_end;
		logic              truncated;
		logic              last_of_run;
		logic [16:0]       stamp_seconds;
		logic [4:0]        stamp_day;
		logic [3:0]        stamp_month;
		logic [8:0]        stamp_year;
	} wad_result_t;

endpackage

// ===== src/wad_stream_ifs.sv =====
// Handshake channels of the word archive deframer: the word input and the result output.
// Depends on wad_pkg for field widths and codes.
interface wad_word_if;
	logic                      valid;
	logic                      ready;
	logic [wad_pkg::WORD_W-1:0] word_in;
	logic                      end_of_stream;

	modport source (output valid, output word_in, output end_of_stream, input ready);
	modport sink (input valid, input word_in, input end_of_stream, output ready);
endinterface

interface wad_result_if;
	logic                       valid;
	logic                       ready;
	wad_pkg::wad_kind_t         word_kind;
	logic [wad_pkg::WORD_W-1:0] word_value;
	logic [wad_pkg::MCNT_W-1:0] member_number;
	wad_pkg::wad_fmt_t          format_code;
	logic                       magic_error;
	logic                       member_end;
	logic                       truncated;
	logic                       last_of_run;
	logic [16:0]                stamp_seconds;
	logic [4:0]                 stamp_day;
	logic [3:0]                 stamp_month;
	logic [8:0]                 stamp_year;

	modport source (
		output valid, output word_kind, output word_value, output member_number,
		output format_code, output magic_error, output member_end, output truncated,
		output last_of_run, output stamp_seconds, output stamp_day, output stamp_month,
		output stamp_year, input ready
	);
	modport sink (
		input valid, input word_kind, input word_value, input member_number,
		input format_code, input magic_error, input member_end, input truncated,
		input last_of_run, input stamp_seconds, input stamp_day, input stamp_month,
		input stamp_year, output ready
	);
endinterface

// ===== src/wad_front.sv =====
// Front part: collects the lookahead words, finds the format and feeds classified entries.
// Depends on wad_pkg and the wad_word_if channel.
module wad_front (
	input  logic                 clk,
	input  logic                 arst_n,
	wad_word_if.sink             words,
	input  wad_pkg::wad_q_stat_t q_stat,
	output logic                 push,
	output wad_pkg::wad_entry_t  push_entry
);

	wad_pkg::wad_front_state_t state_q, state_nxt;
	logic [wad_pkg::WORD_W-1:0] look_q [wad_pkg::LOOK_DEPTH];
	logic [2:0]        cnt_q, cnt_nxt;
	logic [2:0]        idx_q, idx_nxt;
	logic [2:0]        off_q, off_nxt;
	logic [2:0]        upos_q, upos_nxt;
	logic              eos_q, eos_nxt;
	wad_pkg::wad_fmt_t fmt_q, fmt_nxt;
	logic              accept;
	logic              rep_last;

	assign accept   = words.valid && words.ready;
	assign rep_last = (idx_q == cnt_q - 3'd1);

	always_comb begin
		state_nxt   = state_q;
		cnt_nxt     = cnt_q;
		idx_nxt     = idx_q;
		off_nxt     = off_q;
		upos_nxt    = upos_q;
		eos_nxt     = eos_q;
		fmt_nxt     = fmt_q;
		words.ready = 1'b0;
		push        = 1'b0;
		push_entry  = '{word: words.word_in, skind: wad_pkg::SK_MEMBER, fmt: fmt_q,
		                last: 1'b1, eos: words.end_of_stream};
		case (state_q)
			wad_pkg::FS_COLLECT: begin
				words.ready = 1'b1;
				if (accept) begin
					cnt_nxt = cnt_q + 3'd1;
					eos_nxt = words.end_of_stream;
					if (cnt_q == 3'(wad_pkg::LOOK_DEPTH - 1) || words.end_of_stream)
						state_nxt = wad_pkg::FS_DETECT;
				end
			end
			wad_pkg::FS_DETECT: begin
				// Test the fixed offsets in priority order; offsets past the held words never match
				upos_nxt = 3'(wad_pkg::LOOK_DEPTH);
				off_nxt  = 3'd0;
				if (look_q[0] == wad_pkg::MAGIC_WORD) begin
					fmt_nxt = wad_pkg::FMT_OFF0;
				end else if (cnt_q > 3'd1 && look_q[1] == wad_pkg::MAGIC_WORD) begin
					fmt_nxt  = wad_pkg::FMT_OFF1;
					off_nxt  = 3'd1;
					upos_nxt = 3'd0;
				end else if (cnt_q > 3'd4 && look_q[4] == wad_pkg::MAGIC_WORD) begin
					fmt_nxt  = wad_pkg::FMT_OFF4;
					off_nxt  = 3'd4;
					upos_nxt = 3'd1;
				end else if (cnt_q > 3'd5 && look_q[5] == wad_pkg::MAGIC_WORD) begin
					fmt_nxt  = wad_pkg::FMT_OFF5;
					off_nxt  = 3'd5;
					upos_nxt = 3'd1;
				end else begin
					fmt_nxt = wad_pkg::FMT_UNKNOWN;
				end
				idx_nxt   = 3'd0;
				state_nxt = wad_pkg::FS_REPLAY;
			end
			wad_pkg::FS_REPLAY: begin
				push = !q_stat.full;
				push_entry.word = look_q[idx_q];
				if (idx_q < off_q)
					push_entry.skind = (idx_q == upos_q) ? wad_pkg::SK_USER
					                                     : wad_pkg::SK_PREAMBLE;
				push_entry.last = rep_last;
				push_entry.eos  = eos_q && rep_last;
				if (push) begin
					idx_nxt = idx_q + 3'd1;
					if (rep_last) begin
						if (eos_q) begin
							state_nxt = wad_pkg::FS_COLLECT;
							cnt_nxt   = 3'd0;
						end else begin
							state_nxt = wad_pkg::FS_PASS;
						end
					end
				end
			end
			wad_pkg::FS_PASS: begin
				words.ready = !q_stat.full;
				push        = accept;
				if (accept && words.end_of_stream) begin
					state_nxt = wad_pkg::FS_COLLECT;
					cnt_nxt   = 3'd0;
				end
			end
			default: begin
				state_nxt = wad_pkg::FS_COLLECT;
				cnt_nxt   = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wad_pkg::FS_COLLECT;
			cnt_q   <= 3'd0;
			idx_q   <= 3'd0;
			off_q   <= 3'd0;
			upos_q  <= 3'(wad_pkg::LOOK_DEPTH);
			eos_q   <= 1'b0;
			fmt_q   <= wad_pkg::FMT_OFF0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			idx_q   <= idx_nxt;
			off_q   <= off_nxt;
			upos_q  <= upos_nxt;
			eos_q   <= eos_nxt;
			fmt_q   <= fmt_nxt;
		end
	end

	// Lookahead words: payload only, written in collect state
	always_ff @(posedge clk) begin
		if (state_q == wad_pkg::FS_COLLECT && accept)
			look_q[cnt_q] <= words.word_in;
	end

endmodule

// ===== src/wad_queue.sv =====
// Short entry queue between the front and back parts of the deframer.
// Depends on wad_pkg for the entry type and depth.
module wad_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wad_pkg::wad_entry_t  push_entry,
	input  logic                 pop,
	output wad_pkg::wad_entry_t  head,
	output wad_pkg::wad_q_stat_t stat
);

	localparam int PW = $clog2(wad_pkg::QDEPTH);

	wad_pkg::wad_entry_t mem_q [wad_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign stat.full  = (cnt_q == (PW+1)'(wad_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_entry;
	end

endmodule

// ===== src/wad_back.sv =====
// Back part: walks the member header and data, builds each result and holds it for transfer.
// Depends on wad_pkg and the wad_result_if channel.
module wad_back #(
	parameter int MAX_WORDS = 262144
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [wad_pkg::WORD_W-1:0] data_key,
	input  wad_pkg::wad_entry_t        head,
	input  wad_pkg::wad_q_stat_t       q_stat,
	output logic                       pop,
	wad_result_if.source               results
);

	localparam logic [wad_pkg::WORD_W-1:0] LEN_CAP =
		(MAX_WORDS < int'(wad_pkg::REMAIN_MAX)) ? wad_pkg::WORD_W'(MAX_WORDS)
		                                        : wad_pkg::WORD_W'(wad_pkg::REMAIN_MAX);

	wad_pkg::wad_hdr_pos_t        hp_q, hp_nxt;
	logic [wad_pkg::REM_W-1:0]    rem_q, rem_nxt, rem_dec;
	logic [wad_pkg::MCNT_W-1:0]   mcnt_q, mcnt_nxt;
	logic [wad_pkg::REM_W-1:0]    len;
	logic                         mend;
	logic                         ov_q;
	wad_pkg::wad_result_t         res, res_q;

	assign pop     = !q_stat.empty && (!ov_q || results.ready);
	assign len     = (head.word < LEN_CAP) ? head.word[wad_pkg::REM_W-1:0]
	                                       : LEN_CAP[wad_pkg::REM_W-1:0];
	assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	always_comb begin
		hp_nxt  = hp_q;
		rem_nxt = rem_q;
		mend    = 1'b0;
		res     = '0;
		res.word_kind     = wad_pkg::KIND_PREAMBLE;
		res.word_value    = head.word;
		res.member_number = mcnt_q;
		res.format_code   = head.fmt;
		case (head.skind)
			wad_pkg::SK_USER: begin
				res.word_kind  = wad_pkg::KIND_USER;
				res.word_value = head.word ^ wad_pkg::USER_MASK;
			end
			wad_pkg::SK_MEMBER: begin
				case (hp_q)
					wad_pkg::HP_MAGIC: begin
						res.word_kind   = wad_pkg::KIND_MAGIC;
						res.magic_error = (head.word != wad_pkg::MAGIC_WORD);
						hp_nxt = wad_pkg::HP_NAME1;
					end
					wad_pkg::HP_NAME1: begin
						res.word_kind = wad_pkg::KIND_NAME1;
						hp_nxt = wad_pkg::HP_NAME2;
					end
					wad_pkg::HP_NAME2: begin
						res.word_kind = wad_pkg::KIND_NAME2;
						hp_nxt = wad_pkg::HP_STAMP;
					end
					wad_pkg::HP_STAMP: begin
						res.word_kind     = wad_pkg::KIND_TIMESTAMP;
						res.stamp_seconds = head.word[17:1];
						res.stamp_day     = head.word[22:18];
						res.stamp_month   = head.word[26:23];
						res.stamp_year    = head.word[35:27];
						hp_nxt = wad_pkg::HP_LENGTH;
					end
					wad_pkg::HP_LENGTH: begin
						res.word_kind = wad_pkg::KIND_LENGTH;
						if (len == '0) begin
							mend   = 1'b1;
							hp_nxt = wad_pkg::HP_MAGIC;
						end else begin
							rem_nxt = len;
							hp_nxt  = wad_pkg::HP_DATA;
						end
					end
					default: begin
						res.word_kind  = wad_pkg::KIND_DATA;
						res.word_value = head.word ^ data_key;
						rem_nxt = rem_dec;
						if (rem_dec == '0) begin
							mend   = 1'b1;
							hp_nxt = wad_pkg::HP_MAGIC;
						end
					end
				endcase
			end
			default: ;
		endcase
		res.member_end  = mend;
		res.last_of_run = head.last;
		res.truncated   = head.eos && !mend;
		mcnt_nxt = (mend && mcnt_q != '1) ? mcnt_q + 1'b1 : mcnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q   <= wad_pkg::HP_MAGIC;
			rem_q  <= '0;
			mcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				ov_q <= 1'b1;
				if (head.eos) begin
					hp_q   <= wad_pkg::HP_MAGIC;
					rem_q  <= '0;
					mcnt_q <= '0;
				end else begin
					hp_q   <= hp_nxt;
					rem_q  <= rem_nxt;
					mcnt_q <= mcnt_nxt;
				end
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res;
	end

	assign results.valid         = ov_q;
	assign results.word_kind     = res_q.word_kind;
	assign results.word_value    = res_q.word_value;
	assign results.member_number = res_q.member_number;
	assign results.format_code   = res_q.format_code;
	assign results.magic_error   = res_q.magic_error;
	assign results.member_end    = res_q.member_end;
	assign results.truncated     = res_q.truncated;
	assign results.last_of_run   = res_q.last_of_run;
	assign results.stamp_seconds = res_q.stamp_seconds;
	assign results.stamp_day     = res_q.stamp_day;
	assign results.stamp_month   = res_q.stamp_month;
	assign results.stamp_year    = res_q.stamp_year;

endmodule

// ===== src/word_archive_deframer.sv =====
// Top level of the word archive deframer: front, entry queue, back and the key register.
// Depends on wad_pkg, wad_stream_ifs, wad_front, wad_queue and wad_back.
//
// Feed 36-bit archive words on the words channel; every word comes back on the results
// channel, classified as preamble, user, magic, name, timestamp, length or data, with the
// member index, format code and error flags attached. At the start of an archive the first
// six words (fewer if end_of_stream comes sooner) are taken one per cycle into a lookahead
// buffer, then the magic offset is found and the held words are replayed one per cycle
// while the queue has room, during which the words channel holds ready low. After that
// each word passes through at one per cycle, paced by the four-entry queue and the single
// output register; a stalled output holds off the input only once the queue fills. A word
// with end_of_stream set closes the archive and returns everything except data_key to its
// reset state, so the next word starts a new archive.
// Write data_key through cfg_we/cfg_wdata only while no results are outstanding.
module word_archive_deframer #(
	parameter int MAX_WORDS = 262144
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wad_pkg::WORD_W-1:0] cfg_wdata,
	wad_word_if.sink                   words,
	wad_result_if.source               results
);

	logic [wad_pkg::WORD_W-1:0] data_key_q;
	logic                       push;
	logic                       pop;
	wad_pkg::wad_entry_t        push_entry;
	wad_pkg::wad_entry_t        head;
	wad_pkg::wad_q_stat_t       q_stat;

	// Hold the data key; a write lands on the clock edge where cfg_we is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_key_q <= '0;
		end else if (cfg_we) begin
			data_key_q <= cfg_wdata;
		end
	end

	// Front: buffer, detect format, classify and push entries
	wad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (words),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue: decouple the front from output stalls
	wad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// Back: deframe members and hold each result until its transfer
	wad_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_key (data_key_q),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.results  (results)
	);

endmodule

// ===== src/wad_checker.sv =====
// Port-level checks for the word archive deframer, attached by bind.
// Depends on wad_pkg for the kind codes.
module wad_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       o_valid,
	input logic                       o_ready,
	input wad_pkg::wad_kind_t         o_kind,
	input logic [wad_pkg::WORD_W-1:0] o_value,
	input logic                       o_magic_error,
	input logic                       o_member_end,
	input logic                       o_truncated,
	input logic                       o_last,
	input logic [16:0]                o_seconds,
	input logic [4:0]                 o_day,
	input logic [3:0]                 o_month,
	input logic [8:0]                 o_year
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(o_value) && $stable(o_kind))
		else $error("stalled result changed");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_truncated |-> o_last && !o_member_end)
		else $error("truncated flag off the final result");

	a_mend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_member_end |->
			o_kind == wad_pkg::KIND_LENGTH || o_kind == wad_pkg::KIND_DATA)
		else $error("member end on a header word");

	a_magic_kind: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_magic_error |-> o_kind == wad_pkg::KIND_MAGIC)
		else $error("magic error outside magic position");

	a_stamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_kind != wad_pkg::KIND_TIMESTAMP |->
			o_seconds == '0 && o_day == '0 && o_month == '0 && o_year == '0)
		else $error("timestamp fields on a non-timestamp word");

endmodule

bind word_archive_deframer wad_checker u_wad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.o_valid       (results.valid),
	.o_ready       (results.ready),
	.o_kind        (results.word_kind),
	.o_value       (results.word_value),
	.o_magic_error (results.magic_error),
	.o_member_end  (results.member_end),
	.o_truncated   (results.truncated),
	.o_last        (results.last_of_run),
	.o_seconds     (results.stamp_seconds),
	.o_day         (results.stamp_day),
	.o_month       (results.stamp_month),
	.o_year        (results.stamp_year)
);

// ===== bench/word_archive_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for word_archive_deframer: directed archives, then random archives.
// Depends on wad_pkg and the wad_word_if / wad_result_if channels; predicts every result.
module word_archive_deframer_tb;

	localparam int WORD_W = wad_pkg::WORD_W;
	localparam int LOOK_DEPTH = wad_pkg::LOOK_DEPTH;
	localparam int REM_W = wad_pkg::REM_W;
	localparam int MCNT_W = wad_pkg::MCNT_W;
	localparam int MAX_WORDS = 262144;
	localparam longint unsigned LEN_CAP =
		(MAX_WORDS < wad_pkg::REMAIN_MAX) ? MAX_WORDS : wad_pkg::REMAIN_MAX;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_SLACK = 24;
	localparam int CYCLE_LIMIT = 400000;

	// Predicts the classified words of the archive stream and holds them until they
	// come out. Keeps its own copy of the lookahead, header position and key.
	class archive_scoreboard;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] held[LOOK_DEPTH];
		int held_n;
		wad_pkg::wad_fmt_t fmt;
		wad_pkg::wad_hdr_pos_t hdr_pos;
		logic [REM_W-1:0] remaining;
		logic [MCNT_W-1:0] member_idx;
		bit detected;
		wad_pkg::wad_result_t awaited[$];
		int bad, n_words, n_results, n_ends, n_magic_err, n_trunc;
		bit [4:0] fmts_seen;

		function new();
			key = '0;
			bad = 0;
			n_words = 0;
			n_results = 0;
			n_ends = 0;
			n_magic_err = 0;
			n_trunc = 0;
			fmts_seen = '0;
			restart();
		endfunction

		// Everything but the key goes back to its reset value.
		function void restart();
			foreach (held[i]) held[i] = '0;
			held_n = 0;
			fmt = wad_pkg::FMT_OFF0;
			hdr_pos = wad_pkg::HP_MAGIC;
			remaining = '0;
			member_idx = '0;
			detected = 0;
		endfunction

		function wad_pkg::wad_result_t plain_word(wad_pkg::wad_kind_t kind,
				logic [WORD_W-1:0] v);
			wad_pkg::wad_result_t r;
			r = '0;
			r.word_kind = kind;
			r.word_value = v;
			r.member_number = member_idx;
			r.format_code = fmt;
			return r;
		endfunction

		// Classify one word that belongs to the member sequence and advance the header.
		function wad_pkg::wad_result_t deframe_word(logic [WORD_W-1:0] w);
			wad_pkg::wad_result_t r;
			logic [17:0] date;
			longint unsigned len;
			bit mend;
			r = plain_word(wad_pkg::KIND_PREAMBLE, w);
			mend = 0;
			date = w[35:18];
			case (hdr_pos)
				wad_pkg::HP_MAGIC: begin
					r.word_kind = wad_pkg::KIND_MAGIC;
					r.magic_error = (w != wad_pkg::MAGIC_WORD);
					hdr_pos = wad_pkg::HP_NAME1;
				end
				wad_pkg::HP_NAME1: begin
					r.word_kind = wad_pkg::KIND_NAME1;
					hdr_pos = wad_pkg::HP_NAME2;
				end
				wad_pkg::HP_NAME2: begin
					r.word_kind = wad_pkg::KIND_NAME2;
					hdr_pos = wad_pkg::HP_STAMP;
				end
				wad_pkg::HP_STAMP: begin
					r.word_kind = wad_pkg::KIND_TIMESTAMP;
					r.stamp_seconds = w[17:1];
					r.stamp_day = date[4:0];
					r.stamp_month = date[8:5];
					r.stamp_year = date[17:9];
					hdr_pos = wad_pkg::HP_LENGTH;
				end
				wad_pkg::HP_LENGTH: begin
					r.word_kind = wad_pkg::KIND_LENGTH;
					len = (w < LEN_CAP) ? w : LEN_CAP;
					if (len == 0) begin
						mend = 1;
						hdr_pos = wad_pkg::HP_MAGIC;
					end else begin
						remaining = len[REM_W-1:0];
						hdr_pos = wad_pkg::HP_DATA;
					end
				end
				default: begin
					r.word_kind = wad_pkg::KIND_DATA;
					r.word_value = w ^ key;
					if (remaining != 0)
						remaining--;
					if (remaining == 0) begin
						mend = 1;
						hdr_pos = wad_pkg::HP_MAGIC;
					end
				end
			endcase
			if (mend) begin
				r.member_end = 1;
				if (member_idx != '1)
					member_idx++;
			end
			return r;
		endfunction

		// Note one accepted input word and queue the results it causes.
		function void note_word(logic [WORD_W-1:0] w, bit eos);
			wad_pkg::wad_result_t batch[$];
			wad_pkg::wad_result_t r;
			int offset, userpos, k;
			n_words++;
			if (!detected) begin
				if (held_n < LOOK_DEPTH)
					held[held_n] = w;
				held_n++;
				if (held_n < LOOK_DEPTH && !eos)
					return;
				// Search the held words only; offsets past them never match.
				if (held[0] == wad_pkg::MAGIC_WORD) begin
					fmt = wad_pkg::FMT_OFF0; offset = 0; userpos = LOOK_DEPTH;
				end else if (held_n > 1 && held[1] == wad_pkg::MAGIC_WORD) begin
					fmt = wad_pkg::FMT_OFF1; offset = 1; userpos = 0;
				end else if (held_n > 4 && held[4] == wad_pkg::MAGIC_WORD) begin
					fmt = wad_pkg::FMT_OFF4; offset = 4; userpos = 1;
				end else if (held_n > 5 && held[5] == wad_pkg::MAGIC_WORD) begin
					fmt = wad_pkg::FMT_OFF5; offset = 5; userpos = 1;
				end else begin
					fmt = wad_pkg::FMT_UNKNOWN; offset = 0; userpos = LOOK_DEPTH;
				end
				detected = 1;
				for (k = 0; k < held_n; k++) begin
					if (k >= offset)
						batch.push_back(deframe_word(held[k]));
					else if (k == userpos)
						batch.push_back(plain_word(wad_pkg::KIND_USER,
							held[k] ^ wad_pkg::USER_MASK));
					else
						batch.push_back(plain_word(wad_pkg::KIND_PREAMBLE, held[k]));
				end
			end else begin
				batch.push_back(deframe_word(w));
			end
			r = batch.pop_back();
			r.last_of_run = 1;
			if (eos && !r.member_end)
				r.truncated = 1;
			batch.push_back(r);
			foreach (batch[i]) begin
				n_ends += batch[i].member_end;
				n_magic_err += batch[i].magic_error;
				n_trunc += batch[i].truncated;
				fmts_seen[batch[i].format_code] = 1'b1;
				awaited.push_back(batch[i]);
			end
			if (eos)
				restart();
		endfunction

		function void compare_field(string field, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] have);
			if (want !== have) begin
				$display("%0t ns: field %s expected %0h actual %0h", $time, field, want, have);
				bad++;
			end
		endfunction

		function void check_result(wad_pkg::wad_result_t got);
			wad_pkg::wad_result_t want;
			n_results++;
			if (awaited.size() == 0) begin
				$display("%0t ns: result with nothing awaited, expected none actual kind %0d value %0h",
					$time, got.word_kind, got.word_value);
				bad++;
				return;
			end
			want = awaited.pop_front();
			compare_field("word_kind", want.word_kind, got.word_kind);
			compare_field("word_value", want.word_value, got.word_value);
			compare_field("member_number", want.member_number, got.member_number);
			compare_field("format_code", want.format_code, got.format_code);
			compare_field("magic_error", want.magic_error, got.magic_error);
			compare_field("member_end", want.member_end, got.member_end);
			compare_field("truncated", want.truncated, got.truncated);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
			compare_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
			compare_field("stamp_day", want.stamp_day, got.stamp_day);
			compare_field("stamp_month", want.stamp_month, got.stamp_month);
			compare_field("stamp_year", want.stamp_year, got.stamp_year);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [WORD_W-1:0] cfg_wdata = '0;

	wad_word_if word_ch();
	wad_result_if result_ch();

	word_archive_deframer #(.MAX_WORDS(MAX_WORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.words(word_ch),
		.results(result_ch)
	);

	archive_scoreboard sb;
	logic [WORD_W-1:0] archive_words[$];
	bit sender_gaps = 1;
	bit receiver_stalls = 1;
	bit long_hold_req = 0;
	int phase_words;
	int cycle_count = 0;

	always #5 clk = ~clk;

	// Watchdog: a stuck handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results still awaited", $time, sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		wad_pkg::wad_result_t got;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.word_kind = result_ch.word_kind;
			got.word_value = result_ch.word_value;
			got.member_number = result_ch.member_number;
			got.format_code = result_ch.format_code;
			got.magic_error = result_ch.magic_error;
			got.member_end = result_ch.member_end;
			got.truncated = result_ch.truncated;
			got.last_of_run = result_ch.last_of_run;
			got.stamp_seconds = result_ch.stamp_seconds;
			got.stamp_day = result_ch.stamp_day;
			got.stamp_month = result_ch.stamp_month;
			got.stamp_year = result_ch.stamp_year;
			sb.check_result(got);
		end
	end

	// Receiver: random stall bursts, and one long hold-off on request so the
	// queue fills and the block pushes back on its input.
	initial begin : result_pacer
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 0;
			end
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 16) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[WORD_W-1:0];
	endfunction

	// Mostly plausible dates, sometimes raw noise.
	function automatic logic [WORD_W-1:0] stamp_word();
		if ($urandom_range(0, 3) == 0)
			return rand_word();
		return {9'($urandom), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
			18'($urandom)};
	endfunction

	// Append one member to the archive under construction. Return 1 when its length
	// is too large to ever finish, so the archive must end inside it.
	function automatic bit add_member(bit bad_magic);
		int pick, len;
		archive_words.push_back((bad_magic || $urandom_range(0, 9) == 0) ?
			rand_word() : wad_pkg::MAGIC_WORD);
		archive_words.push_back(rand_word());
		archive_words.push_back(rand_word());
		archive_words.push_back(stamp_word());
		pick = $urandom_range(0, 19);
		if (pick == 19) begin
			case ($urandom_range(0, 3))
				0: archive_words.push_back('1);
				1: archive_words.push_back(WORD_W'(LEN_CAP));
				2: archive_words.push_back(WORD_W'(LEN_CAP - 1));
				default: archive_words.push_back(WORD_W'(wad_pkg::REMAIN_MAX));
			endcase
			repeat ($urandom_range(1, 3)) archive_words.push_back(rand_word());
			return 1;
		end
		len = (pick < 3) ? 0 : $urandom_range(1, 6);
		archive_words.push_back(WORD_W'(len));
		repeat (len) archive_words.push_back(rand_word());
		return 0;
	endfunction

	// Offer one word and hold it until the transfer; called at a falling edge.
	task automatic push_word(logic [WORD_W-1:0] w, bit eos);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			word_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.word_in <= w;
		word_ch.end_of_stream <= eos;
		do @(posedge clk); while (word_ch.ready !== 1'b1);
		sb.note_word(w, eos);
		phase_words++;
		@(negedge clk);
	endtask

	// Send the built archive up to and including word last, which carries end_of_stream.
	task automatic send_queue(int last);
		int i;
		for (i = 0; i <= last; i++)
			push_word(archive_words[i], i == last);
		archive_words.delete();
	endtask

	// One random archive: pick a layout, fill members, then close it either after
	// the last word or at a random cut.
	task automatic send_archive();
		int layout, members, m, cut;
		bit open;
		layout = $urandom_range(0, 9);
		open = 0;
		case (layout)
			3, 4: archive_words.push_back(rand_word());
			5: repeat (4) archive_words.push_back(rand_word());
			6: repeat (5) archive_words.push_back(rand_word());
			default: ;
		endcase
		if (layout == 7) begin
			// plain noise, usually with no magic anywhere
			repeat ($urandom_range(1, 10)) archive_words.push_back(rand_word());
		end else begin
			members = $urandom_range(1, 4);
			for (m = 0; m < members && !open; m++)
				open = add_member(layout >= 8 && m == 0);
		end
		cut = archive_words.size() - 1;
		if ($urandom_range(0, 4) == 0)
			cut = $urandom_range(0, cut);
		send_queue(cut);
	endtask

	task automatic run_archives(int n);
		phase_words = 0;
		while (phase_words < n)
			send_archive();
	endtask

	// Wait for every predicted result, then let the pipeline go quiet.
	task automatic settle();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// Write the key only once the block is idle.
	task automatic load_key(logic [WORD_W-1:0] k);
		word_ch.valid <= 1'b0;
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		sb.key = k;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		word_ch.valid = 1'b0;
		word_ch.word_in = '0;
		word_ch.end_of_stream = 1'b0;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Magic at offset 0: field extremes, a one-word member, then a zero-length
		// member whose length word closes the archive.
		archive_words = '{wad_pkg::MAGIC_WORD, '0, '1, '1, 36'd1, '1,
			wad_pkg::MAGIC_WORD, rand_word(), rand_word(), '0, '0};
		send_queue(archive_words.size() - 1);
		// Short lookahead: user word then magic, stream ends on the magic.
		archive_words = '{rand_word(), wad_pkg::MAGIC_WORD};
		send_queue(1);
		// No magic at all: unknown format, huge length, ends inside the data.
		archive_words = '{rand_word(), rand_word(), rand_word(), rand_word(), '1,
			rand_word(), rand_word()};
		send_queue(6);
		// Magic at offset 4: preamble and user words ahead of the header.
		archive_words = '{rand_word(), rand_word(), rand_word(), rand_word(),
			wad_pkg::MAGIC_WORD, rand_word()};
		send_queue(5);
		// Single-word archive.
		archive_words = '{wad_pkg::MAGIC_WORD};
		send_queue(0);

		load_key('1);
		run_archives(45);

		// Pressure: receiver holds off while the sender keeps offering.
		load_key(rand_word());
		long_hold_req = 1;
		sender_gaps = 0;
		run_archives(45);
		sender_gaps = 1;

		load_key('0);
		run_archives(45);

		// Last stretch at full rate on both sides.
		load_key(rand_word());
		sender_gaps = 0;
		receiver_stalls = 0;
		run_archives(45);

		word_ch.valid <= 1'b0;
		settle();
		$display("covered %0d words in, %0d results out, %0d member ends, %0d bad magics, %0d truncations",
			sb.n_words, sb.n_results, sb.n_ends, sb.n_magic_err, sb.n_trunc);
		$display("format codes seen %05b (bit per code), four key settings, one long output stall",
			sb.fmts_seen);
		if (sb.bad == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
